// File: design/ima_adpcm_encoder_core_assert.svh
// assertion macros used by the adpcm encoder back end
`ifndef IMA_ADPCM_ENCODER_CORE_ASSERT_SVH
`define IMA_ADPCM_ENCODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define IMA_ENC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define IMA_ENC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define IMA_ENC_ASSERT_NOW(label, clk, rst, ante, cons)
`define IMA_ENC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: design/ima_enc_pkg.sv
// types, constants and tables of the adpcm encoder
package ima_enc_pkg;

   // input item
   typedef struct packed {
      logic signed [15:0] sample;
      logic               last_sample;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] packed_byte;
      logic       last_byte;
   } rsp_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_head_type;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   localparam int IDX_MAX = 88;
   localparam logic [6:0] IDX_MAX_VAL = 7'(IDX_MAX);

   localparam logic signed [17:0] PRED_MAX = 18'sd32767;
   localparam logic signed [17:0] PRED_MIN = -18'sd32768;

   // standard ima step sizes
   localparam logic [14:0] STEP_TABLE [0:IDX_MAX] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
      15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
      15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
      15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
      15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
      15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
      15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
      15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
      15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
      15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   // step index adjustment by code magnitude
   localparam logic signed [4:0] INDEX_ADJUST [0:7] = '{
      -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
   };

endpackage

// File: design/ima_enc_front.sv
// input side: accepts samples into a two-entry queue
module ima_enc_front
   import ima_enc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_data,
   input  logic           pop,
   output queue_head_type head
);

   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   req_type            slot_ff [Q_DEPTH];
   logic               push;

   // stall only on a full queue
   assign req_stall = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign push      = req_valid && !req_stall;

   // head of queue
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

// File: design/ima_enc_back.sv
// encode side: predictor, step index, nibble packing and output register
`include "ima_adpcm_encoder_core_assert.svh"
module ima_enc_back
   import ima_enc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data
);

   logic signed [15:0] pred_ff, pred_in;
   logic [6:0]         idx_ff, idx_in;
   logic [3:0]         pend_ff, pend_in;
   logic               wait_ff, wait_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_data_ff, out_data_in;

   logic [16:0]        step17, half17, quarter17;
   logic signed [16:0] diff;
   logic               neg;
   logic [16:0]        mag, rem1, rem2, vpdiff;
   logic               bit2, bit1, bit0;
   logic [3:0]         code;
   logic signed [17:0] pred_sum;
   logic signed [15:0] pred_new;
   logic signed [8:0]  idx_sum;
   logic [6:0]         idx_new;
   logic               last;
   logic               emit;

   assign last = head.item.last_sample;

   // take the head when the output register can hold a result
   assign pop  = head.valid && (!out_valid_ff || !rsp_stall);
   assign emit = pop && (wait_ff || last);

   // three compare stages against the step size, the first two also subtracting
   always_comb begin
      step17    = {2'b00, STEP_TABLE[idx_ff]};
      half17    = step17 >> 1;
      quarter17 = step17 >> 2;
      diff      = {head.item.sample[15], head.item.sample} - {pred_ff[15], pred_ff};
      neg       = diff[16];
      mag       = neg ? 17'(-diff) : 17'(diff);
      bit2      = (mag >= step17);
      rem1      = bit2 ? mag - step17 : mag;
      bit1      = (rem1 >= half17);
      rem2      = bit1 ? rem1 - half17 : rem1;
      bit0      = (rem2 >= quarter17);
      vpdiff    = (step17 >> 3) + (bit2 ? step17 : 17'd0)
                + (bit1 ? half17 : 17'd0) + (bit0 ? quarter17 : 17'd0);
      code      = {neg, bit2, bit1, bit0};
   end

   // predictor update with saturation
   always_comb begin
      if (neg) begin
         pred_sum = {{2{pred_ff[15]}}, pred_ff} - $signed({1'b0, vpdiff});
      end else begin
         pred_sum = {{2{pred_ff[15]}}, pred_ff} + $signed({1'b0, vpdiff});
      end
      priority if (pred_sum > PRED_MAX) begin
         pred_new = 16'sh7fff;
      end else if (pred_sum < PRED_MIN) begin
         pred_new = -16'sh8000;
      end else begin
         pred_new = pred_sum[15:0];
      end
   end

   // step index update, held within the table
   always_comb begin
      idx_sum = $signed({2'b00, idx_ff}) + 9'(INDEX_ADJUST[code[2:0]]);
      priority if (idx_sum < 9'sd0) begin
         idx_new = '0;
      end else if (idx_sum > $signed({2'b00, IDX_MAX_VAL})) begin
         idx_new = IDX_MAX_VAL;
      end else begin
         idx_new = idx_sum[6:0];
      end
   end

   // state and pairing
   always_comb begin
      pred_in = pred_ff;
      idx_in  = idx_ff;
      pend_in = pend_ff;
      wait_in = wait_ff;
      if (pop) begin
         if (last) begin
            pred_in = '0;
            idx_in  = '0;
            pend_in = '0;
            wait_in = 1'b0;
         end else begin
            pred_in = pred_new;
            idx_in  = idx_new;
            pend_in = wait_ff ? 4'd0 : code;
            wait_in = !wait_ff;
         end
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_data_in.packed_byte = wait_ff ? {pend_ff, code} : {code, 4'd0};
         out_data_in.last_byte   = last;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff      <= '0;
         idx_ff       <= '0;
         pend_ff      <= '0;
         wait_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pred_ff      <= pred_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         wait_ff      <= wait_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // checks
   `IMA_ENC_ASSERT_NOW(a_idx_range, clock, reset, 1'b1, idx_ff <= IDX_MAX_VAL)
   `IMA_ENC_ASSERT_NEXT(a_last_clears, clock, reset, pop && last,
      !wait_ff && pred_ff == 16'sd0 && idx_ff == 7'd0)
   `IMA_ENC_ASSERT_NEXT(a_emit_shows, clock, reset, emit, out_valid_ff)
   `IMA_ENC_ASSERT_NOW(a_pend_clear, clock, reset, !wait_ff, pend_ff == 4'd0)

endmodule

// File: design/ima_adpcm_encoder_core.sv
// top level of the ima adpcm 4-bit encoder with nibble packing
//
//   channel | ports              | payload
//   --------+--------------------+------------------------------
//   request | req_valid/stall    | req_data: sample, last_sample
//   result  | rsp_valid/stall    | rsp_data: packed_byte, last_byte
//
// one sample per cycle sustained while rsp_stall is low; the encode
// stage's predictor and step index loop closes through its own registers.
// a byte comes out via the queue register, then the output register.
// reset is synchronous and empties the queue, the output register and the
// encoder state. req_stall rises only when both queue entries are occupied;
// the encode stage holds while a result waits under rsp_stall.
module ima_adpcm_encoder_core
   import ima_enc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   queue_head_type head;
   logic           pop;

   // sample queue
   ima_enc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pop       (pop),
      .head      (head)
   );

   // encoder and packer
   ima_enc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
